// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Bezier patch evaluator package
// Sizes, types and helper functions shared by the patch evaluator modules.
// ----------------------------------------------------------------------------
package bpe_pkg;

   localparam int GRID_SIZE   = 4;
   localparam int COORD_WIDTH = 32;

   localparam int PT_W      = 32;
   localparam int IDX_W     = 2;
   localparam int PARAM_W   = 17;
   localparam int LANES     = 3;
   localparam int FRAC_BITS = 16;

   localparam int WORD_W = LANES * COORD_WIDTH;
   localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE);
   localparam int CNT_W  = $clog2(GRID_SIZE);
   localparam int PROD_W = COORD_WIDTH + PARAM_W + 2;

   // Issue to writeback distance of the blend unit, in cycles.
   localparam int LERP_LATENCY = 3;
   localparam int GAP_W        = 2;

   localparam logic [PARAM_W-1:0] ONE_Q16    = PARAM_W'(65536);
   localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(32768);

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [ADDR_W-1:0]             addr_type;

   // One blend operation as it travels from the sequencer to writeback.
   typedef struct packed {
      logic     valid;
      logic     src_grid;
      logic     use_v;
      logic     last;
      addr_type addr_a;
      addr_type addr_b;
   } lerp_op_type;

   function automatic coord_type load_coord(input logic signed [PT_W-1:0] p);
      return COORD_WIDTH'(p);
   endfunction

   function automatic logic [PARAM_W-1:0] clamp_param(input logic [PARAM_W-1:0] p);
      return (p > ONE_Q16) ? ONE_Q16 : p;
   endfunction

endpackage

// ----- rtl/bpe_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, each read registered.
// ----------------------------------------------------------------------------
module bpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- rtl/bpe_lerp.sv -----
// ----------------------------------------------------------------------------
// Blend unit
// Three-lane linear interpolation a + round((b - a) * t), product registered.
// ----------------------------------------------------------------------------
module bpe_lerp (
   input  logic                          clock,
   input  logic [bpe_pkg::WORD_W-1:0]    a_word,
   input  logic [bpe_pkg::WORD_W-1:0]    b_word,
   input  logic [bpe_pkg::PARAM_W-1:0]   t,
   output logic [bpe_pkg::WORD_W-1:0]    res_word
);
   import bpe_pkg::*;

   logic signed [PARAM_W:0] t_s;

   assign t_s = signed'({1'b0, t});

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      coord_type                 a;
      coord_type                 b;
      logic signed [COORD_WIDTH:0] diff;
      logic signed [PROD_W-1:0]  prod_in;
      logic signed [PROD_W-1:0]  prod_ff;
      coord_type                 a_ff;
      logic signed [PROD_W-1:0]  rounded;
      logic signed [PROD_W-1:0]  shifted;

      assign a       = signed'(a_word[l*COORD_WIDTH +: COORD_WIDTH]);
      assign b       = signed'(b_word[l*COORD_WIDTH +: COORD_WIDTH]);
      assign diff    = (COORD_WIDTH+1)'(b) - (COORD_WIDTH+1)'(a);
      assign prod_in = diff * t_s;

      always_ff @(posedge clock) begin
         prod_ff <= prod_in;
         a_ff    <= a;
      end

      // The result lies between a and b, so the truncated sum cannot wrap.
      assign rounded = prod_ff + signed'(ROUND_HALF);
      assign shifted = rounded >>> FRAC_BITS;
      assign res_word[l*COORD_WIDTH +: COORD_WIDTH] = a_ff + COORD_WIDTH'(shifted);
   end

endmodule

// ----- rtl/bpe_sequencer.sv -----
// ----------------------------------------------------------------------------
// Evaluation sequencer
// Walks the row passes and then the column passes of de Casteljau reduction.
// ----------------------------------------------------------------------------
module bpe_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 eval_start,
   input  logic                 done,
   output logic                 busy,
   output bpe_pkg::lerp_op_type op
);
   import bpe_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ROW   = 4'b0010,
      S_COL   = 4'b0100,
      S_DRAIN = 4'b1000
   } seq_state_type;

   localparam logic [CNT_W-1:0] LEVEL_TOP = CNT_W'(GRID_SIZE - 1);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [GAP_W-1:0] GAP_TOP   = GAP_W'(LERP_LATENCY - 1);

   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] level_ff, level_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [GAP_W-1:0] gap_ff, gap_in;
   addr_type         row_addr;
   addr_type         col_addr;
   logic             pass_end;

   assign row_addr = ADDR_W'(int'(row_ff) * GRID_SIZE + int'(idx_ff));
   assign col_addr = ADDR_W'(int'(idx_ff) * GRID_SIZE);
   assign pass_end = (idx_ff == level_ff - CNT_ONE);

   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      idx_in   = idx_ff;
      row_in   = row_ff;
      gap_in   = gap_ff;
      op       = '0;
      case (state_ff)
         S_IDLE: begin
            if (eval_start) begin
               state_in = S_ROW;
               level_in = LEVEL_TOP;
               idx_in   = '0;
               row_in   = '0;
            end
         end
         S_ROW: begin
            // Rows are interleaved so that a result is written back before
            // the next pass of the same row reads it.
            op.valid    = 1'b1;
            op.src_grid = (level_ff == LEVEL_TOP);
            op.addr_a   = row_addr;
            op.addr_b   = row_addr + ADDR_W'(1);
            if (row_ff == LEVEL_TOP) begin
               row_in = '0;
               if (pass_end) begin
                  idx_in = '0;
                  if (level_ff == CNT_ONE) begin
                     state_in = S_COL;
                     level_in = LEVEL_TOP;
                     gap_in   = GAP_TOP;
                  end else begin
                     level_in = level_ff - CNT_ONE;
                  end
               end else begin
                  idx_in = idx_ff + CNT_ONE;
               end
            end else begin
               row_in = row_ff + CNT_ONE;
            end
         end
         S_COL: begin
            // Column steps depend on each other, so each waits out the
            // writeback of the one before it.
            if (gap_ff != '0) begin
               gap_in = gap_ff - GAP_W'(1);
            end else begin
               op.valid  = 1'b1;
               op.use_v  = 1'b1;
               op.last   = (level_ff == CNT_ONE);
               op.addr_a = col_addr;
               op.addr_b = col_addr + ADDR_W'(GRID_SIZE);
               gap_in    = GAP_TOP;
               if (pass_end) begin
                  idx_in = '0;
                  if (level_ff == CNT_ONE) begin
                     state_in = S_DRAIN;
                  end else begin
                     level_in = level_ff - CNT_ONE;
                  end
               end else begin
                  idx_in = idx_ff + CNT_ONE;
               end
            end
         end
         S_DRAIN: begin
            if (done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         level_ff <= '0;
         idx_ff   <= '0;
         row_ff   <= '0;
         gap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         idx_ff   <= idx_in;
         row_ff   <= row_in;
         gap_ff   <= gap_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- rtl/bezier_patch_evaluator.sv -----
// ----------------------------------------------------------------------------
// Bezier patch evaluator
// Tensor-product de Casteljau evaluation of a grid of 3D control points.
//
//   channel   handshake          word
//   req       start, busy        req_type, point row/col/x/y/z, param u/v
//   rsp       rsp_valid strobe   rsp_surface_x/y/z
//
// A load word is taken without raising busy.
// An evaluate word holds busy high through the row passes, the column passes
// and the pipeline drain; rsp_valid pulses in the first cycle with busy low.
// The row passes issue one blend per cycle into the shared blend unit; each
// column step waits out the read-to-writeback latency of the step before it.
// Reset returns the sequencer to idle; control points must be reloaded.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bezier_patch_evaluator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_type,
   input  logic [bpe_pkg::IDX_W-1:0]           req_point_row,
   input  logic [bpe_pkg::IDX_W-1:0]           req_point_col,
   input  logic signed [bpe_pkg::PT_W-1:0]     req_point_x,
   input  logic signed [bpe_pkg::PT_W-1:0]     req_point_y,
   input  logic signed [bpe_pkg::PT_W-1:0]     req_point_z,
   input  logic [bpe_pkg::PARAM_W-1:0]         req_param_u,
   input  logic [bpe_pkg::PARAM_W-1:0]         req_param_v,
   output logic                                rsp_valid,
   output logic signed [bpe_pkg::PT_W-1:0]     rsp_surface_x,
   output logic signed [bpe_pkg::PT_W-1:0]     rsp_surface_y,
   output logic signed [bpe_pkg::PT_W-1:0]     rsp_surface_z
);
   import bpe_pkg::*;

   logic                 accept;
   logic                 load_we;
   logic                 eval_start;
   addr_type             load_addr;
   logic [WORD_W-1:0]    load_word;
   logic [PARAM_W-1:0]   u_ff;
   logic [PARAM_W-1:0]   v_ff;
   lerp_op_type          op;
   lerp_op_type          st1_ff;
   lerp_op_type          st2_ff;
   logic [WORD_W-1:0]    grid_rd_a;
   logic [WORD_W-1:0]    grid_rd_b;
   logic [WORD_W-1:0]    scr_rd_a;
   logic [WORD_W-1:0]    scr_rd_b;
   logic [WORD_W-1:0]    a_word;
   logic [WORD_W-1:0]    b_word;
   logic [PARAM_W-1:0]   t_sel;
   logic [WORD_W-1:0]    res_word;
   logic                 scr_we;
   logic                 done;
   logic                 rsp_valid_ff;
   logic signed [PT_W-1:0] surf_x_ff;
   logic signed [PT_W-1:0] surf_y_ff;
   logic signed [PT_W-1:0] surf_z_ff;

   assign accept     = start && !busy;
   assign eval_start = accept && (req_type == REQ_EVAL);
   assign load_we    = accept && (req_type == REQ_LOAD)
                       && (int'(req_point_row) < GRID_SIZE)
                       && (int'(req_point_col) < GRID_SIZE);
   assign load_addr  = ADDR_W'(int'(req_point_row) * GRID_SIZE + int'(req_point_col));
   assign load_word  = {load_coord(req_point_z), load_coord(req_point_y),
                        load_coord(req_point_x)};

   always_ff @(posedge clock) begin
      if (eval_start) begin
         u_ff <= clamp_param(req_param_u);
         v_ff <= clamp_param(req_param_v);
      end
   end

   bpe_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .eval_start (eval_start),
      .done       (done),
      .busy       (busy),
      .op         (op)
   );

   // Control points as loaded.
   bpe_ram #(
      .WIDTH (WORD_W),
      .DEPTH (GRID_SIZE * GRID_SIZE)
   ) u_grid (
      .clock     (clock),
      .wr_en     (load_we),
      .wr_addr   (load_addr),
      .wr_data   (load_word),
      .rd_addr_a (op.addr_a),
      .rd_addr_b (op.addr_b),
      .rd_data_a (grid_rd_a),
      .rd_data_b (grid_rd_b)
   );

   // Intermediate points, reduced in place.
   bpe_ram #(
      .WIDTH (WORD_W),
      .DEPTH (GRID_SIZE * GRID_SIZE)
   ) u_scratch (
      .clock     (clock),
      .wr_en     (scr_we),
      .wr_addr   (st2_ff.addr_a),
      .wr_data   (res_word),
      .rd_addr_a (op.addr_a),
      .rd_addr_b (op.addr_b),
      .rd_data_a (scr_rd_a),
      .rd_data_b (scr_rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff <= '0;
         st2_ff <= '0;
      end else begin
         st1_ff <= op;
         st2_ff <= st1_ff;
      end
   end

   assign a_word = st1_ff.src_grid ? grid_rd_a : scr_rd_a;
   assign b_word = st1_ff.src_grid ? grid_rd_b : scr_rd_b;
   assign t_sel  = st1_ff.use_v ? v_ff : u_ff;

   bpe_lerp u_lerp (
      .clock    (clock),
      .a_word   (a_word),
      .b_word   (b_word),
      .t        (t_sel),
      .res_word (res_word)
   );

   assign scr_we = st2_ff.valid && !st2_ff.last;
   assign done   = st2_ff.valid && st2_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         surf_x_ff <= PT_W'(signed'(res_word[0*COORD_WIDTH +: COORD_WIDTH]));
         surf_y_ff <= PT_W'(signed'(res_word[1*COORD_WIDTH +: COORD_WIDTH]));
         surf_z_ff <= PT_W'(signed'(res_word[2*COORD_WIDTH +: COORD_WIDTH]));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_surface_x = surf_x_ff;
   assign rsp_surface_y = surf_y_ff;
   assign rsp_surface_z = surf_z_ff;

   `ASSERT_NXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe lasted two cycles")
   `ASSERT_IMP(a_pipe_in_busy, op.valid || st2_ff.valid, busy, "blend in flight while idle")
   `ASSERT_NXT(a_eval_starts, eval_start, busy, "evaluate word did not start the sequencer")

endmodule
